[src/lpps_pkg.sv]
// Shared types and constants for the LED pattern PWM sequencer.
// No dependencies; used by the controller, the datapath and the top level.
package lpps_pkg;

  localparam int NUM_LEDS    = 8;
  localparam int NUM_EFFECTS = 8;
  localparam int MAX_STEPS   = 256;

  localparam int LED_W    = 3;
  localparam int EFF_W    = 3;
  localparam int STEP_W   = 8;
  localparam int PER_W    = 9;
  localparam int REP_W    = 16;
  localparam int REM_W    = 25;
  localparam int MEM_AW   = EFF_W + STEP_W;
  localparam int MEM_DEPTH = NUM_EFFECTS * MAX_STEPS;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 8;

  localparam logic [CFG_AW-1:0] CFG_NUM_LEDS    = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_ACTIVE_LOW  = 1'd1;

  typedef enum logic [1:0] {
    REQ_TICK        = 2'd0,
    REQ_CMD         = 2'd1,
    REQ_LOAD_STEP   = 2'd2,
    REQ_LOAD_PERIOD = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CMD_OFF   = 2'd0,
    CMD_ON    = 2'd1,
    CMD_IDLE  = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_INACTIVE = 2'd0,
    ACT_ACTIVE   = 2'd1,
    ACT_PWM      = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STS_IDLE   = 2'd0,
    STS_OFF    = 2'd1,
    STS_ACTIVE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic mem_cycle;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_busy;
  } dp_sts_t;

endpackage

[src/lpps_ctrl.sv]
// Controller state machine of the LED pattern PWM sequencer.
// Depends on lpps_pkg; drives datapath commands, reads datapath status.
module lpps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpps_pkg::dp_sts_t sts,
  output lpps_pkg::dp_cmd_t cmd
);

  lpps_pkg::state_t state_r, state_nxt;
  logic             go;

  // Finish the item unless its result would overwrite a held output.
  assign go = !(sts.has_result && sts.out_busy);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpps_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lpps_pkg::S_READ;
      end
      lpps_pkg::S_READ: begin
        state_nxt = lpps_pkg::S_EXEC;
      end
      lpps_pkg::S_EXEC: begin
        if (go) state_nxt = in_valid ? lpps_pkg::S_READ : lpps_pkg::S_IDLE;
      end
      default: state_nxt = lpps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = !((state_r == lpps_pkg::S_IDLE) ||
                      ((state_r == lpps_pkg::S_EXEC) && go));
    cmd.capture   = in_valid && !in_stall;
    cmd.mem_cycle = (state_r == lpps_pkg::S_READ);
    cmd.commit    = (state_r == lpps_pkg::S_EXEC) && go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/lpps_dp.sv]
// Datapath of the LED pattern PWM sequencer: item registers, channel state,
// effect periods, pattern memory and output register. Depends on lpps_pkg.
module lpps_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpps_pkg::dp_cmd_t             cmd,
  output lpps_pkg::dp_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [lpps_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [lpps_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic [1:0]                    in_req_type,
  input  logic [lpps_pkg::LED_W-1:0]    in_led,
  input  logic [1:0]                    in_cmd,
  input  logic [lpps_pkg::EFF_W-1:0]    in_effect_id,
  input  logic [lpps_pkg::REP_W-1:0]    in_repeat_count,
  input  logic [lpps_pkg::STEP_W-1:0]   in_step_index,
  input  logic [lpps_pkg::STEP_W-1:0]   in_step_value,
  input  logic [lpps_pkg::PER_W-1:0]    in_effect_period,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpps_pkg::LED_W-1:0]    out_led,
  output logic [1:0]                    out_drive_action,
  output logic                          out_pin_level,
  output logic [lpps_pkg::PER_W-1:0]    out_pwm_period,
  output logic [lpps_pkg::PER_W-1:0]    out_pwm_duty,
  output logic [1:0]                    out_led_status
);

  // Configuration registers
  logic [3:0]                     num_leds_r;
  logic [lpps_pkg::NUM_LEDS-1:0]  active_low_r;

  // Captured item
  lpps_pkg::req_t                 req_r;
  logic [lpps_pkg::LED_W-1:0]     led_r;
  lpps_pkg::cmd_t                 cmd_r;
  logic [lpps_pkg::EFF_W-1:0]     eid_r;
  logic [lpps_pkg::REP_W-1:0]     rep_r;
  logic [lpps_pkg::STEP_W-1:0]    sidx_r;
  logic [lpps_pkg::STEP_W-1:0]    sval_r;
  logic [lpps_pkg::PER_W-1:0]     eper_r;

  // Channel and effect state
  logic [lpps_pkg::PER_W-1:0]     eff_len_r  [lpps_pkg::NUM_EFFECTS];
  logic                           ch_run_r   [lpps_pkg::NUM_LEDS];
  logic [lpps_pkg::EFF_W-1:0]     ch_eff_r   [lpps_pkg::NUM_LEDS];
  logic [lpps_pkg::STEP_W-1:0]    ch_step_r  [lpps_pkg::NUM_LEDS];
  logic [lpps_pkg::REM_W-1:0]     ch_rem_r   [lpps_pkg::NUM_LEDS];
  logic [lpps_pkg::REP_W-1:0]     ch_reps_r  [lpps_pkg::NUM_LEDS];
  lpps_pkg::status_t              ch_sts_r   [lpps_pkg::NUM_LEDS];

  logic [7:0]                     pat_mem    [lpps_pkg::MEM_DEPTH];
  logic [7:0]                     rd_r;
  logic [lpps_pkg::REM_W-1:0]     prod_r;

  logic                           out_valid_r;
  logic [lpps_pkg::LED_W-1:0]     out_led_r;
  lpps_pkg::action_t              out_act_r;
  logic                           out_pin_r;
  logic [lpps_pkg::PER_W-1:0]     out_per_r;
  logic [lpps_pkg::PER_W-1:0]     out_duty_r;
  lpps_pkg::status_t              out_sts_r;

  // Decode of the captured item
  logic                           led_ok, eff_ok, step_ok, led_cmd_ok;
  logic [lpps_pkg::EFF_W-1:0]     eff_sel;
  logic [lpps_pkg::PER_W-1:0]     per;
  logic                           inact, act_lvl;
  logic                           run, spent;
  logic [lpps_pkg::STEP_W-1:0]    st;
  logic [lpps_pkg::PER_W-1:0]     st_inc;
  logic [lpps_pkg::PER_W-1:0]     duty9;
  logic                           mem_we;

  logic                           has_res;
  lpps_pkg::action_t              res_act;
  logic                           res_pin;
  logic [lpps_pkg::PER_W-1:0]     res_per;
  logic [lpps_pkg::PER_W-1:0]     res_duty;
  lpps_pkg::status_t              res_sts;

  logic                           upd_start, upd_force, upd_tick, upd_period;
  lpps_pkg::status_t              force_sts;

  assign led_ok     = 32'(led_r) < lpps_pkg::NUM_LEDS;
  assign eff_ok     = 32'(eid_r) < lpps_pkg::NUM_EFFECTS;
  assign step_ok    = 32'(sidx_r) < lpps_pkg::MAX_STEPS;
  assign led_cmd_ok = led_ok && ({1'b0, led_r} < num_leds_r);
  // One read port on the period table: the channel's effect for a tick,
  // the item's effect otherwise.
  assign eff_sel    = (req_r == lpps_pkg::REQ_TICK) ? ch_eff_r[led_r] : eid_r;
  assign per        = eff_len_r[eff_sel];
  assign inact      = active_low_r[led_r];
  assign act_lvl    = !inact;
  assign run        = ch_run_r[led_r];
  assign st         = ch_step_r[led_r];
  assign st_inc     = {1'b0, st} + 9'd1;
  assign spent      = (ch_rem_r[led_r] == '0) && (ch_reps_r[led_r] != '0);
  assign duty9      = {1'b0, rd_r};
  assign mem_we     = cmd.mem_cycle && (req_r == lpps_pkg::REQ_LOAD_STEP) &&
                      eff_ok && step_ok;

  always_comb begin
    has_res    = 1'b0;
    res_act    = lpps_pkg::ACT_INACTIVE;
    res_pin    = 1'b0;
    res_per    = '0;
    res_duty   = '0;
    res_sts    = ch_sts_r[led_r];
    upd_start  = 1'b0;
    upd_force  = 1'b0;
    upd_tick   = 1'b0;
    upd_period = 1'b0;
    force_sts  = lpps_pkg::STS_IDLE;
    unique case (req_r)
      lpps_pkg::REQ_TICK: begin
        if (led_ok && run) begin
          has_res = 1'b1;
          res_per = per;
          if (spent) begin
            res_pin = inact;
          end else begin
            upd_tick = 1'b1;
            if (rd_r == 8'd0) begin
              res_pin  = inact;
              res_duty = 9'd1;
            end else if (duty9 == per) begin
              res_act  = lpps_pkg::ACT_ACTIVE;
              res_pin  = act_lvl;
              res_duty = (per == '0) ? '0 : per - 9'd1;
            end else begin
              res_act  = lpps_pkg::ACT_PWM;
              res_duty = duty9;
            end
          end
        end
      end
      lpps_pkg::REQ_CMD: begin
        if (led_cmd_ok) begin
          if (cmd_r == lpps_pkg::CMD_START) begin
            if (eff_ok && (per != '0) &&
                !(run && (ch_eff_r[led_r] == eid_r) && (ch_rem_r[led_r] != '0))) begin
              has_res   = 1'b1;
              upd_start = 1'b1;
              res_act   = lpps_pkg::ACT_PWM;
              res_per   = per;
              res_duty  = 9'd1;
              res_sts   = lpps_pkg::STS_ACTIVE;
            end
          end else begin
            has_res   = 1'b1;
            upd_force = 1'b1;
            unique case (cmd_r)
              lpps_pkg::CMD_OFF: begin
                force_sts = lpps_pkg::STS_OFF;
                res_pin   = inact;
              end
              lpps_pkg::CMD_ON: begin
                force_sts = lpps_pkg::STS_ACTIVE;
                res_act   = lpps_pkg::ACT_ACTIVE;
                res_pin   = act_lvl;
              end
              default: begin
                force_sts = lpps_pkg::STS_IDLE;
                res_pin   = inact;
              end
            endcase
            res_sts = force_sts;
          end
        end
      end
      lpps_pkg::REQ_LOAD_PERIOD: begin
        upd_period = eff_ok;
      end
      default: begin
      end
    endcase
  end

  assign sts.has_result = has_res;
  assign sts.out_busy   = out_valid_r && out_stall;

  // Configuration and item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_leds_r   <= '0;
      active_low_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lpps_pkg::CFG_NUM_LEDS:   num_leds_r   <= cfg_wdata[3:0];
        lpps_pkg::CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[lpps_pkg::NUM_LEDS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= lpps_pkg::req_t'(in_req_type);
      led_r  <= in_led;
      cmd_r  <= lpps_pkg::cmd_t'(in_cmd);
      eid_r  <= in_effect_id;
      rep_r  <= in_repeat_count;
      sidx_r <= in_step_index;
      sval_r <= in_step_value;
      eper_r <= in_effect_period;
    end
  end

  // Pattern memory: step loads write, ticks read the channel's current step
  always_ff @(posedge clk) begin
    if (mem_we) pat_mem[{eid_r, sidx_r}] <= sval_r;
    if (cmd.mem_cycle) rd_r <= pat_mem[{ch_eff_r[led_r], ch_step_r[led_r]}];
  end

  // Total step count of a started effect
  always_ff @(posedge clk) begin
    if (cmd.mem_cycle) prod_r <= {9'd0, rep_r} * {16'd0, per};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpps_pkg::NUM_EFFECTS; i++) eff_len_r[i] <= '0;
      for (int i = 0; i < lpps_pkg::NUM_LEDS; i++) begin
        ch_run_r[i]  <= 1'b0;
        ch_eff_r[i]  <= '0;
        ch_step_r[i] <= '0;
        ch_rem_r[i]  <= '0;
        ch_reps_r[i] <= '0;
        ch_sts_r[i]  <= lpps_pkg::STS_IDLE;
      end
    end else if (cmd.commit) begin
      if (upd_period) begin
        eff_len_r[eid_r] <= (32'(eper_r) > lpps_pkg::MAX_STEPS) ?
                            9'(lpps_pkg::MAX_STEPS) : eper_r;
      end
      if (upd_start) begin
        ch_run_r[led_r]  <= 1'b1;
        ch_eff_r[led_r]  <= eid_r;
        ch_step_r[led_r] <= '0;
        ch_reps_r[led_r] <= rep_r;
        ch_rem_r[led_r]  <= prod_r;
        ch_sts_r[led_r]  <= lpps_pkg::STS_ACTIVE;
      end
      if (upd_force) begin
        ch_run_r[led_r] <= 1'b0;
        ch_sts_r[led_r] <= force_sts;
      end
      if (upd_tick) begin
        // wrap the step index at the live period
        ch_step_r[led_r] <= (st_inc >= per) ? '0 : st_inc[lpps_pkg::STEP_W-1:0];
        if (ch_rem_r[led_r] != '0) ch_rem_r[led_r] <= ch_rem_r[led_r] - 25'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && has_res) begin
      out_led_r  <= led_r;
      out_act_r  <= res_act;
      out_pin_r  <= res_pin;
      out_per_r  <= res_per;
      out_duty_r <= res_duty;
      out_sts_r  <= res_sts;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led          = out_led_r;
  assign out_drive_action = out_act_r;
  assign out_pin_level    = out_pin_r;
  assign out_pwm_period   = out_per_r;
  assign out_pwm_duty     = out_duty_r;
  assign out_led_status   = out_sts_r;

endmodule

[src/led_pattern_pwm_sequencer.sv]
// Top level of the LED pattern PWM sequencer.
// Depends on lpps_pkg, lpps_ctrl and lpps_dp.
//
// Input channel (in_valid / in_stall): one request per transfer, a tick, a
//   channel command, a pattern step load or an effect period load. Load
//   periods and pattern steps before starting effects.
// Result channel (out_valid / out_stall): at most one result per request,
//   the channel, drive action, forced pin level, PWM period and duty and the
//   channel status afterwards. Loads and ignored requests give no result.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 num_leds,
//   1 active_low_mask); write only while the block is idle.
// Timing: a transfer is followed by a read cycle (pattern memory, repeat
//   count times period) and an execute cycle that takes the next request,
//   so the next request transfers in the execute cycle of the last unless it
//   holds; the execute cycle loads the result into the register on out_valid.
// Reset (rst_n low, synchronous): channels idle and stopped, effect periods
//   and config registers zero, output empty; pattern memory is not cleared.
// Back-pressure: a finished result waits in the output register while the
//   next request is taken; the execute cycle holds only if it has a new
//   result and the output register is still stalled.
module led_pattern_pwm_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lpps_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [lpps_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [lpps_pkg::LED_W-1:0]    in_led,
  input  logic [1:0]                    in_cmd,
  input  logic [lpps_pkg::EFF_W-1:0]    in_effect_id,
  input  logic [lpps_pkg::REP_W-1:0]    in_repeat_count,
  input  logic [lpps_pkg::STEP_W-1:0]   in_step_index,
  input  logic [lpps_pkg::STEP_W-1:0]   in_step_value,
  input  logic [lpps_pkg::PER_W-1:0]    in_effect_period,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpps_pkg::LED_W-1:0]    out_led,
  output logic [1:0]                    out_drive_action,
  output logic                          out_pin_level,
  output logic [lpps_pkg::PER_W-1:0]    out_pwm_period,
  output logic [lpps_pkg::PER_W-1:0]    out_pwm_duty,
  output logic [1:0]                    out_led_status
);

  lpps_pkg::dp_cmd_t dp_cmd;
  lpps_pkg::dp_sts_t dp_sts;

  // Sequence capture, read and execute for each request
  lpps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // Hold channel state, pattern memory and the output register
  lpps_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .sts              (dp_sts),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_led           (in_led),
    .in_cmd           (in_cmd),
    .in_effect_id     (in_effect_id),
    .in_repeat_count  (in_repeat_count),
    .in_step_index    (in_step_index),
    .in_step_value    (in_step_value),
    .in_effect_period (in_effect_period),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_led          (out_led),
    .out_drive_action (out_drive_action),
    .out_pin_level    (out_pin_level),
    .out_pwm_period   (out_pwm_period),
    .out_pwm_duty     (out_pwm_duty),
    .out_led_status   (out_led_status)
  );

  // A transfer is always followed by the read cycle, which takes nothing
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken during read cycle");

  // Capture leads to exactly one read cycle
  a_read_once: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.capture |=> dp_cmd.mem_cycle ##1 !dp_cmd.mem_cycle)
    else $error("read cycle sequence broken");

  // A new result only comes from an execute step
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(dp_cmd.commit && dp_sts.has_result))
    else $error("result without execute");

  // Never overwrite a stalled result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> !(dp_sts.has_result && out_valid && out_stall))
    else $error("stalled result overwritten");

endmodule

[dv/tb_led_pattern_pwm_sequencer.sv]
// Self-checking testbench for led_pattern_pwm_sequencer: directed and random requests,
// with a cycle-accurate-free predictor of channel drives compared result by result.
// Depends on lpps_pkg and the led_pattern_pwm_sequencer RTL only.
module tb_led_pattern_pwm_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog limit, with a wide margin over the worst case per transfer.
  localparam int LIMIT_CYCLES = 600000;
  // Capture, read and execute stages plus the output register.
  localparam int DRAIN_CYCLES = 8;

  // One request as presented on the input channel.
  typedef struct packed {
    lpps_pkg::req_t kind;
    logic [2:0]     led;
    lpps_pkg::cmd_t cmd;
    logic [2:0]     effect_id;
    logic [15:0]    repeat_count;
    logic [7:0]     step_index;
    logic [7:0]     step_value;
    logic [8:0]     effect_period;
  } led_req_t;

  // One channel drive as returned on the result channel.
  typedef struct packed {
    logic [2:0]        led;
    lpps_pkg::action_t action;
    logic              pin;
    logic [8:0]        period;
    logic [8:0]        duty;
    lpps_pkg::status_t status;
  } led_drive_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [lpps_pkg::CFG_AW-1:0]    cfg_addr = lpps_pkg::CFG_NUM_LEDS;
  logic [lpps_pkg::CFG_DW-1:0]    cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_req_type = lpps_pkg::REQ_TICK;
  logic [lpps_pkg::LED_W-1:0]     in_led = '0;
  logic [1:0]                     in_cmd = lpps_pkg::CMD_OFF;
  logic [lpps_pkg::EFF_W-1:0]     in_effect_id = '0;
  logic [lpps_pkg::REP_W-1:0]     in_repeat_count = '0;
  logic [lpps_pkg::STEP_W-1:0]    in_step_index = '0;
  logic [lpps_pkg::STEP_W-1:0]    in_step_value = '0;
  logic [lpps_pkg::PER_W-1:0]     in_effect_period = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [lpps_pkg::LED_W-1:0]     out_led;
  logic [1:0]                     out_drive_action;
  logic                           out_pin_level;
  logic [lpps_pkg::PER_W-1:0]     out_pwm_period;
  logic [lpps_pkg::PER_W-1:0]     out_pwm_duty;
  logic [1:0]                     out_led_status;

  // Idle rates in percent of cycles for the sender and the receiver.
  int send_idle_pct = 38;
  int stall_pct     = 49;

  int cycle_cnt    = 0;
  int mismatch_cnt = 0;
  // Requests transferred so far, fills included.
  int counted_cnt  = 0;

  // Drives still owed by the block, oldest first.
  led_drive_t drive_q[$];

  // Shadow of the block: registers, pattern memory and per-channel sequencer state.
  logic [3:0]         num_leds_reg;
  logic [7:0]         act_low_reg;
  logic [7:0]         pat_mem   [lpps_pkg::NUM_EFFECTS][lpps_pkg::MAX_STEPS];
  bit                 pat_known [lpps_pkg::NUM_EFFECTS][lpps_pkg::MAX_STEPS];
  logic [8:0]         eff_len   [lpps_pkg::NUM_EFFECTS];
  bit                 ch_run    [lpps_pkg::NUM_LEDS];
  logic [2:0]         ch_eff    [lpps_pkg::NUM_LEDS];
  logic [7:0]         ch_step   [lpps_pkg::NUM_LEDS];
  logic [24:0]        ch_left   [lpps_pkg::NUM_LEDS];
  logic [15:0]        ch_reps   [lpps_pkg::NUM_LEDS];
  lpps_pkg::status_t  ch_sts    [lpps_pkg::NUM_LEDS];

  led_pattern_pwm_sequencer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_led           (in_led),
    .in_cmd           (in_cmd),
    .in_effect_id     (in_effect_id),
    .in_repeat_count  (in_repeat_count),
    .in_step_index    (in_step_index),
    .in_step_value    (in_step_value),
    .in_effect_period (in_effect_period),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_led          (out_led),
    .out_drive_action (out_drive_action),
    .out_pin_level    (out_pin_level),
    .out_pwm_period   (out_pwm_period),
    .out_pwm_duty     (out_pwm_duty),
    .out_led_status   (out_led_status)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    num_leds_reg = '0;
    act_low_reg  = '0;
    for (int e = 0; e < lpps_pkg::NUM_EFFECTS; e++) begin
      eff_len[e] = '0;
      for (int s = 0; s < lpps_pkg::MAX_STEPS; s++) begin
        pat_mem[e][s]   = '0;
        pat_known[e][s] = 1'b0;
      end
    end
    for (int l = 0; l < lpps_pkg::NUM_LEDS; l++) begin
      ch_run[l]  = 1'b0;
      ch_eff[l]  = '0;
      ch_step[l] = '0;
      ch_left[l] = '0;
      ch_reps[l] = '0;
      ch_sts[l]  = lpps_pkg::STS_IDLE;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_cnt++;
    $display("[%0d] mismatch on %s: expected %0d, got %0d", cycle_cnt, what, want, got);
  endtask

  // Compute the drive that one accepted request causes and advance the shadow state.
  // Returns 0 when the request gives no result.
  function automatic bit predict_led_drive(input led_req_t rq, output led_drive_t dv);
    logic       inact;
    logic       lit;
    logic [8:0] per;
    logic [7:0] st;
    logic [7:0] duty;
    logic [2:0] e;
    logic [2:0] l;
    l     = rq.led;
    inact = act_low_reg[l];
    lit   = ~inact;
    dv    = '0;
    dv.led = l;
    case (rq.kind)
      lpps_pkg::REQ_LOAD_STEP: begin
        pat_mem[rq.effect_id][rq.step_index]   = rq.step_value;
        pat_known[rq.effect_id][rq.step_index] = 1'b1;
        return 1'b0;
      end
      lpps_pkg::REQ_LOAD_PERIOD: begin
        // Saturate oversized periods to the pattern depth.
        eff_len[rq.effect_id] = (rq.effect_period > lpps_pkg::MAX_STEPS) ?
                                9'(lpps_pkg::MAX_STEPS) : rq.effect_period;
        return 1'b0;
      end
      lpps_pkg::REQ_CMD: begin
        if (4'(l) >= num_leds_reg)
          return 1'b0;
        if (rq.cmd == lpps_pkg::CMD_START) begin
          per = eff_len[rq.effect_id];
          // Drop starts of absent effects and restarts of one still counting.
          if (per == '0)
            return 1'b0;
          if (ch_run[l] && ch_eff[l] == rq.effect_id && ch_left[l] != '0)
            return 1'b0;
          ch_run[l]  = 1'b1;
          ch_eff[l]  = rq.effect_id;
          ch_step[l] = '0;
          ch_reps[l] = rq.repeat_count;
          ch_left[l] = 25'(25'(rq.repeat_count) * 25'(per));
          ch_sts[l]  = lpps_pkg::STS_ACTIVE;
          dv.action  = lpps_pkg::ACT_PWM;
          dv.period  = per;
          dv.duty    = 9'd1;
          dv.status  = lpps_pkg::STS_ACTIVE;
          return 1'b1;
        end
        ch_run[l] = 1'b0;
        case (rq.cmd)
          lpps_pkg::CMD_OFF: begin
            ch_sts[l] = lpps_pkg::STS_OFF;
            dv.action = lpps_pkg::ACT_INACTIVE;
            dv.pin    = inact;
          end
          lpps_pkg::CMD_ON: begin
            ch_sts[l] = lpps_pkg::STS_ACTIVE;
            dv.action = lpps_pkg::ACT_ACTIVE;
            dv.pin    = lit;
          end
          default: begin
            ch_sts[l] = lpps_pkg::STS_IDLE;
            dv.action = lpps_pkg::ACT_INACTIVE;
            dv.pin    = inact;
          end
        endcase
        dv.status = ch_sts[l];
        return 1'b1;
      end
      default: begin
        if (!ch_run[l])
          return 1'b0;
        e         = ch_eff[l];
        per       = eff_len[e];
        st        = ch_step[l];
        dv.period = per;
        dv.status = ch_sts[l];
        // A finite effect whose count is spent keeps forcing the LED dark.
        if (ch_left[l] == '0 && ch_reps[l] != '0) begin
          dv.action = lpps_pkg::ACT_INACTIVE;
          dv.pin    = inact;
          return 1'b1;
        end
        duty = pat_mem[e][st];
        if (duty == '0) begin
          dv.action = lpps_pkg::ACT_INACTIVE;
          dv.pin    = inact;
          dv.duty   = 9'd1;
        end else if ({1'b0, duty} == per) begin
          dv.action = lpps_pkg::ACT_ACTIVE;
          dv.pin    = lit;
          dv.duty   = per - 9'd1;
        end else begin
          dv.action = lpps_pkg::ACT_PWM;
          dv.duty   = {1'b0, duty};
        end
        // Wrap on the live period, which may have shrunk under a running effect.
        ch_step[l] = (10'(st) + 10'd1 >= 10'(per)) ? 8'd0 : st + 8'd1;
        if (ch_left[l] != '0)
          ch_left[l] = ch_left[l] - 25'd1;
        return 1'b1;
      end
    endcase
  endfunction

  // A tick on a live, unspent channel reads the pattern step it stands on.
  function automatic bit tick_needs_step(input logic [2:0] l);
    return ch_run[l] && !(ch_left[l] == '0 && ch_reps[l] != '0) &&
           !pat_known[ch_eff[l]][ch_step[l]];
  endfunction

  // Duty values that hit the forced-dark and forced-lit cases often.
  function automatic logic [7:0] pick_duty(input logic [8:0] per);
    int r;
    r = $urandom_range(9);
    if (r < 2)
      return 8'd0;
    if (r < 4)
      return per[7:0];
    return 8'($urandom);
  endfunction

  // Present one request, hold it until the transfer, then book its expected drive.
  task automatic transfer_request(input led_req_t rq);
    led_drive_t dv;
    bit         has_drive;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_req_type      <= rq.kind;
    in_led           <= rq.led;
    in_cmd           <= rq.cmd;
    in_effect_id     <= rq.effect_id;
    in_repeat_count  <= rq.repeat_count;
    in_step_index    <= rq.step_index;
    in_step_value    <= rq.step_value;
    in_effect_period <= rq.effect_period;
    do
      @(posedge clk);
    while (in_stall);
    has_drive = predict_led_drive(rq, dv);
    if (has_drive)
      drive_q.push_back(dv);
    counted_cnt++;
  endtask

  // Fill the step a tick would read if it was never written, then send the request.
  task automatic issue_request(input led_req_t rq);
    led_req_t fill;
    if (rq.kind == lpps_pkg::REQ_TICK && tick_needs_step(rq.led)) begin
      fill            = rq;
      fill.kind       = lpps_pkg::REQ_LOAD_STEP;
      fill.effect_id  = ch_eff[rq.led];
      fill.step_index = ch_step[rq.led];
      fill.step_value = pick_duty(eff_len[ch_eff[rq.led]]);
      transfer_request(fill);
    end
    transfer_request(rq);
  endtask

  function automatic led_req_t make_request(input lpps_pkg::req_t kind, input int l,
                                            input lpps_pkg::cmd_t c,
                                            input int eid, input int rep, input int idx,
                                            input int val, input int per);
    led_req_t rq;
    rq.kind          = kind;
    rq.led           = 3'(l);
    rq.cmd           = c;
    rq.effect_id     = 3'(eid);
    rq.repeat_count  = 16'(rep);
    rq.step_index    = 8'(idx);
    rq.step_value    = 8'(val);
    rq.effect_period = 9'(per);
    return rq;
  endfunction

  task automatic send_tick(input int l);
    issue_request(make_request(lpps_pkg::REQ_TICK, l, lpps_pkg::CMD_OFF, 0, 0, 0, 0, 0));
  endtask

  task automatic send_cmd(input int l, input lpps_pkg::cmd_t c, input int eid,
                          input int rep);
    issue_request(make_request(lpps_pkg::REQ_CMD, l, c, eid, rep, 0, 0, 0));
  endtask

  task automatic load_step(input int eid, input int idx, input int val);
    issue_request(make_request(lpps_pkg::REQ_LOAD_STEP, 0, lpps_pkg::CMD_OFF, eid, 0,
                               idx, val, 0));
  endtask

  task automatic load_period(input int eid, input int per);
    issue_request(make_request(lpps_pkg::REQ_LOAD_PERIOD, 0, lpps_pkg::CMD_OFF, eid, 0,
                               0, 0, per));
  endtask

  // Drop valid, wait for every owed drive, then let the pipeline empty of loads.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lpps_pkg::CFG_AW-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == lpps_pkg::CFG_NUM_LEDS)
      num_leds_reg = val[3:0];
    else
      act_low_reg = val;
  endtask

  // Mostly well-formed traffic: ticks on live channels, starts of loaded effects,
  // forced states, pattern and period loads; the rest is fully random noise.
  function automatic led_req_t random_led_request();
    led_req_t rq;
    int       pick;
    int       base;
    int       r;
    rq.kind          = lpps_pkg::req_t'(2'($urandom));
    rq.led           = 3'($urandom);
    rq.cmd           = lpps_pkg::cmd_t'(2'($urandom));
    rq.effect_id     = 3'($urandom);
    rq.repeat_count  = 16'($urandom);
    rq.step_index    = 8'($urandom);
    rq.step_value    = 8'($urandom);
    rq.effect_period = 9'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      rq.kind = lpps_pkg::REQ_TICK;
      base    = $urandom_range(7);
      if ($urandom_range(3) != 0)
        for (int k = 0; k < lpps_pkg::NUM_LEDS; k++)
          if (ch_run[3'(base + k)]) begin
            rq.led = 3'(base + k);
            break;
          end
    end else if (pick < 65) begin
      rq.kind = lpps_pkg::REQ_CMD;
      rq.cmd  = lpps_pkg::CMD_START;
      base    = $urandom_range(7);
      if ($urandom_range(4) != 0)
        for (int k = 0; k < lpps_pkg::NUM_EFFECTS; k++)
          if (eff_len[3'(base + k)] != '0) begin
            rq.effect_id = 3'(base + k);
            break;
          end
      r = $urandom_range(9);
      if (r < 2)
        rq.repeat_count = '0;
      else if (r > 2)
        rq.repeat_count = 16'($urandom_range(1, 3));
    end else if (pick < 73) begin
      rq.kind = lpps_pkg::REQ_CMD;
      rq.cmd  = lpps_pkg::cmd_t'($urandom_range(2));
    end else if (pick < 83) begin
      rq.kind = lpps_pkg::REQ_LOAD_STEP;
      if (eff_len[rq.effect_id] != '0 && eff_len[rq.effect_id] < 9'd256 &&
          $urandom_range(4) != 0)
        rq.step_index = 8'($urandom_range(0, eff_len[rq.effect_id] - 1));
      rq.step_value = pick_duty(eff_len[rq.effect_id]);
    end else if (pick < 90) begin
      rq.kind = lpps_pkg::REQ_LOAD_PERIOD;
      r = $urandom_range(9);
      if (r == 0)
        rq.effect_period = '0;
      else if (r == 1)
        rq.effect_period = 9'd256;
      else if (r > 2)
        rq.effect_period = 9'($urandom_range(1, 8));
    end
    return rq;
  endfunction

  // Short hand-picked sequence over every request type, command and corner.
  task automatic test_directed();
    write_reg(lpps_pkg::CFG_NUM_LEDS, 8'd8);
    write_reg(lpps_pkg::CFG_ACTIVE_LOW, 8'h0F);
    load_period(0, 4);
    load_period(1, 511);    // saturates to the full pattern depth
    load_period(2, 1);
    load_step(0, 0, 0);     // forced dark
    load_step(0, 1, 4);     // duty equal to the period: forced lit
    load_step(0, 2, 255);
    load_step(0, 3, 1);
    send_cmd(0, lpps_pkg::CMD_START, 0, 1);
    send_cmd(0, lpps_pkg::CMD_START, 0, 1);   // same effect still counting: dropped
    repeat (5) send_tick(0);                  // last one lands on the spent count
    send_cmd(0, lpps_pkg::CMD_START, 0, 2);   // spent, so a restart is taken
    send_cmd(1, lpps_pkg::CMD_START, 7, 3);   // absent effect: dropped
    send_tick(3);                             // channel not running: no drive
    send_cmd(1, lpps_pkg::CMD_OFF, 0, 0);
    send_cmd(2, lpps_pkg::CMD_ON, 0, 0);
    send_cmd(3, lpps_pkg::CMD_IDLE, 0, 0);
    send_cmd(7, lpps_pkg::CMD_START, 1, 65535);
    send_tick(7);
    send_cmd(5, lpps_pkg::CMD_START, 2, 0);   // runs forever
    repeat (2) send_tick(5);
  endtask

  // Register extremes: no channel accepts commands, then all polarity bits set.
  task automatic test_register_extremes();
    settle_idle();
    write_reg(lpps_pkg::CFG_NUM_LEDS, 8'd0);
    write_reg(lpps_pkg::CFG_ACTIVE_LOW, 8'hFF);
    send_cmd(0, lpps_pkg::CMD_ON, 0, 0);
    send_cmd(4, lpps_pkg::CMD_START, 0, 1);
    send_tick(7);                   // ticks ignore the channel count
    send_tick(5);
    settle_idle();
    write_reg(lpps_pkg::CFG_NUM_LEDS, 8'd8);
    send_cmd(7, lpps_pkg::CMD_ON, 0, 0);
    send_cmd(6, lpps_pkg::CMD_OFF, 0, 0);
    send_cmd(3, lpps_pkg::CMD_IDLE, 0, 0);
  endtask

  task automatic test_random_traffic(input int n_items, input logic [7:0] leds,
                                     input logic [7:0] mask);
    int stop_at;
    settle_idle();
    write_reg(lpps_pkg::CFG_NUM_LEDS, leds);
    write_reg(lpps_pkg::CFG_ACTIVE_LOW, mask);
    stop_at = counted_cnt + n_items;
    while (counted_cnt < stop_at)
      issue_request(random_led_request());
  endtask

  // Compare each transferred result with the oldest owed drive.
  always @(posedge clk) begin
    led_drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        flag_mismatch("unexpected result, led", 0, out_led);
      end else begin
        want = drive_q.pop_front();
        if (out_led !== want.led)
          flag_mismatch("led", want.led, out_led);
        if (out_drive_action !== want.action)
          flag_mismatch("drive_action", want.action, out_drive_action);
        if (out_pin_level !== want.pin)
          flag_mismatch("pin_level", want.pin, out_pin_level);
        if (out_pwm_period !== want.period)
          flag_mismatch("pwm_period", want.period, out_pwm_period);
        if (out_pwm_duty !== want.duty)
          flag_mismatch("pwm_duty", want.duty, out_pwm_duty);
        if (out_led_status !== want.status)
          flag_mismatch("led_status", want.status, out_led_status);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender idles less than the receiver stalls.
    send_idle_pct = 38;
    stall_pct     = 49;
    test_directed();
    test_register_extremes();
    test_random_traffic(471, 8'd8, 8'($urandom));

    // Swap the pressure: sender idles more than the receiver stalls.
    send_idle_pct = 49;
    stall_pct     = 38;
    test_random_traffic(471, 8'($urandom_range(1, 7)), 8'hFF);

    // Full rate on both sides.
    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_traffic(471, 8'd8, 8'h00);

    settle_idle();
    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/lpps_pkg.sv
src/lpps_ctrl.sv
src/lpps_dp.sv
src/led_pattern_pwm_sequencer.sv
dv/tb_led_pattern_pwm_sequencer.sv
